/* rtl/core/mbmd_pkg.sv */
// ----------------------------------------------------------------------------
// mbmd_pkg
// Shared widths, codes, threshold types and threshold arithmetic for the
// masked macroblock motion detector.
// ----------------------------------------------------------------------------
package mbmd_pkg;

	localparam int BLOCK_SLOTS_DEF = 2048;

	localparam int IDX_W     = 11;
	localparam int SAD_W     = 8;
	localparam int SENS_W    = 7;
	localparam int RCOUNT_W  = 12;
	localparam int HIT_W     = 12;
	localparam int CNT_THR_W = 11;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 12;

	localparam logic [HIT_W-1:0]  HIT_MAX  = '1;
	localparam logic [SENS_W-1:0] SENS_MAX = 7'd100;

	// Input item kinds
	localparam logic KIND_MASK = 1'b0;
	localparam logic KIND_SAD  = 1'b1;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SENS   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RCOUNT = 1'd1;

	typedef struct packed {
		logic [SAD_W-1:0]     sad_thr;
		logic [CNT_THR_W-1:0] cnt_thr;
	} thr_t;

	// (100 - s) / 5 + 5, with /5 as a multiply by 205 and a shift by 10
	function automatic logic [SAD_W-1:0] sad_thr_f(input logic [SENS_W-1:0] s);
		logic [SENS_W-1:0] x;
		logic [14:0]       p;
		x = SENS_MAX - s;
		p = 15'(x) * 15'd205;
		return SAD_W'(p[14:10]) + SAD_W'(5);
	endfunction

	// 30 * (100 - s) / 100 = 3 * (100 - s) / 10, /10 as multiply by 205 >> 11
	function automatic logic [4:0] base_thr_f(input logic [SENS_W-1:0] s);
		logic [SENS_W-1:0] x;
		logic [8:0]        y;
		logic [15:0]       p;
		x = SENS_MAX - s;
		y = 9'(x) * 9'd3;
		p = 16'(y) * 16'd205;
		return p[15:11];
	endfunction

endpackage

/* rtl/core/mbmd_if.sv */
// ----------------------------------------------------------------------------
// mbmd_if
// Valid/ready channels of the motion detector: input items, results and
// configuration writes.
// ----------------------------------------------------------------------------

// Input item channel
interface mbmd_item_if;
	logic                       valid;
	logic                       ready;
	logic                       kind;
	logic [mbmd_pkg::IDX_W-1:0] block_index;
	logic [mbmd_pkg::SAD_W-1:0] sad_value;
	logic                       region_bit;
	logic                       frame_end;

	modport source (output valid, kind, block_index, sad_value, region_bit, frame_end,
		input ready);
	modport sink (input valid, kind, block_index, sad_value, region_bit, frame_end,
		output ready);
endinterface

// Result channel
interface mbmd_res_if;
	logic                       valid;
	logic                       ready;
	logic                       frame_motion;
	logic                       alarm;
	logic [mbmd_pkg::HIT_W-1:0] hit_count;

	modport source (output valid, frame_motion, alarm, hit_count, input ready);
	modport sink (input valid, frame_motion, alarm, hit_count, output ready);
endinterface

// Configuration write channel
interface mbmd_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [mbmd_pkg::CFG_IDX_W-1:0] addr;
	logic [mbmd_pkg::CFG_DAT_W-1:0] data;

	modport source (output valid, addr, data, input ready);
	modport sink (input valid, addr, data, output ready);
endinterface

/* rtl/core/mbmd_ram.sv */
// ----------------------------------------------------------------------------
// mbmd_ram
// Generic simple dual-port RAM: one write port and one registered read port.
// ----------------------------------------------------------------------------
module mbmd_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2048,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* rtl/core/mbmd_thresh.sv */
// ----------------------------------------------------------------------------
// mbmd_thresh
// Derives the SAD threshold and the block count threshold from the
// sensitivity and region count registers, registered once.
// ----------------------------------------------------------------------------
module mbmd_thresh import mbmd_pkg::*; (
	input  logic                clk,
	input  logic [SENS_W-1:0]   sensitivity,
	input  logic [RCOUNT_W-1:0] region_count,
	output thr_t                thr
);

	logic [SENS_W-1:0]    sens_c;
	logic [4:0]           base_c;
	logic [23:0]          cap_p;
	logic [CNT_THR_W-1:0] cap_c;
	logic [CNT_THR_W-1:0] cnt_c;
	thr_t                 thr_q;

	// Clamp sensitivity to 100
	assign sens_c = (sensitivity > SENS_MAX) ? SENS_MAX : sensitivity;

	// Raise the base threshold to 2, then cap at region_count / 3
	assign base_c = (base_thr_f(sens_c) < 5'd2) ? 5'd2 : base_thr_f(sens_c);
	assign cap_p  = 24'(region_count) * 24'd2731;
	assign cap_c  = cap_p[23:13];
	assign cnt_c  = (CNT_THR_W'(base_c) >= cap_c) ? cap_c : CNT_THR_W'(base_c);

	// Hold thresholds in registers
	always_ff @(posedge clk) begin
		thr_q.sad_thr <= sad_thr_f(sens_c);
		thr_q.cnt_thr <= cnt_c;
	end

	assign thr = thr_q;

endmodule

/* rtl/core/masked_block_motion_detector.sv */
// ----------------------------------------------------------------------------
// masked_block_motion_detector
// Counts watched macroblocks whose SAD exceeds a sensitivity-driven threshold
// and reports frame motion and a two-frame alarm at each frame end.
//
// Channel   Modport  Transaction
// items     sink     mask write or SAD sample (kind, index, sad, bit, end)
// results   source   frame_motion, alarm, hit_count at each frame end
// cfg       sink     register write: 0 sensitivity, 1 region_count
//
// One item per cycle unless a stalled result holds stage 1; a frame-end item
// passes through stage 1 into the result register. Mask writes and mask reads
// share one RAM, whose read is registered. After reset the mask RAM is cleared
// entry by entry with items held off; configuration writes are taken
// throughout. A stalled result holds the item in stage 1 and input ready drops.
// ----------------------------------------------------------------------------
module masked_block_motion_detector import mbmd_pkg::*; #(
	parameter int BLOCK_SLOTS = BLOCK_SLOTS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	mbmd_item_if.sink     items,
	mbmd_res_if.source    results,
	mbmd_cfg_if.sink      cfg
);

	localparam int AW = $clog2(BLOCK_SLOTS);
	localparam int CW = IDX_W + AW + 1;
	localparam logic [AW-1:0] LAST_ADDR = AW'(BLOCK_SLOTS - 1);

	logic [SENS_W-1:0]   sens_q;
	logic [RCOUNT_W-1:0] rcount_q;
	thr_t                thr;

	logic                clr_q;
	logic [AW-1:0]       clr_addr_q;

	logic [CW-1:0]       idx_w;
	logic [AW-1:0]       idx_addr;
	logic                in_range;
	logic                accept;

	logic                ram_we;
	logic [AW-1:0]       ram_waddr;
	logic                ram_wdata;
	logic                ram_re;
	logic                ram_rdata;

	logic                valid_s1;
	logic                kind_s1;
	logic [SAD_W-1:0]    sad_s1;
	logic                fend_s1;
	logic                inr_s1;

	logic                s1_result;
	logic                out_free;
	logic                s1_go;
	logic                hit;
	logic [HIT_W-1:0]    hits_next;
	logic                motion;

	logic [HIT_W-1:0]    running_q;
	logic                prev_q;
	logic                out_valid_q;
	logic                motion_q;
	logic                alarm_q;
	logic [HIT_W-1:0]    hits_q;

	// Configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sens_q   <= '0;
			rcount_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.addr)
				CFG_SENS:   sens_q   <= cfg.data[SENS_W-1:0];
				CFG_RCOUNT: rcount_q <= cfg.data[RCOUNT_W-1:0];
				default:    ;
			endcase
		end
	end

	mbmd_thresh u_thresh (
		.clk          (clk),
		.sensitivity  (sens_q),
		.region_count (rcount_q),
		.thr          (thr)
	);

	// Clear the mask RAM after reset, one entry per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			if (clr_addr_q == LAST_ADDR) begin
				clr_q <= 1'b0;
			end else begin
				clr_addr_q <= clr_addr_q + AW'(1);
			end
		end
	end

	// Decode the index against the store depth
	assign idx_w    = CW'(items.block_index);
	assign idx_addr = idx_w[AW-1:0];
	assign in_range = idx_w < CW'(BLOCK_SLOTS);

	// Stage 1 advance and input ready
	assign s1_result   = valid_s1 && (kind_s1 == KIND_SAD) && fend_s1;
	assign out_free    = !out_valid_q || results.ready;
	assign s1_go       = valid_s1 && (!s1_result || out_free);
	assign items.ready = !clr_q && (!valid_s1 || s1_go);
	assign accept      = items.valid && items.ready;

	// Mask RAM: write on clear or mask write, read on SAD sample
	assign ram_we    = clr_q || (accept && (items.kind == KIND_MASK) && in_range);
	assign ram_waddr = clr_q ? clr_addr_q : idx_addr;
	assign ram_wdata = clr_q ? 1'b0 : items.region_bit;
	assign ram_re    = accept && (items.kind == KIND_SAD);

	mbmd_ram #(
		.WIDTH (1),
		.DEPTH (BLOCK_SLOTS)
	) u_mask_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (idx_addr),
		.rdata (ram_rdata)
	);

	// Stage 1 registers, aligned with the RAM read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1 <= items.kind;
			sad_s1  <= items.sad_value;
			fend_s1 <= items.frame_end;
			inr_s1  <= in_range;
		end
	end

	// Hit test and saturating count
	assign hit       = (kind_s1 == KIND_SAD) && inr_s1 && ram_rdata && (sad_s1 > thr.sad_thr);
	assign hits_next = (hit && (running_q != HIT_MAX)) ? running_q + HIT_W'(1) : running_q;
	assign motion    = hits_next > HIT_W'(thr.cnt_thr);

	// Advance frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= '0;
			prev_q    <= 1'b0;
		end else if (s1_go && (kind_s1 == KIND_SAD)) begin
			if (fend_s1) begin
				running_q <= '0;
				prev_q    <= motion;
			end else begin
				running_q <= hits_next;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go && s1_result) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && s1_result) begin
			motion_q <= motion;
			alarm_q  <= motion && prev_q;
			hits_q   <= hits_next;
		end
	end

	assign results.valid        = out_valid_q;
	assign results.frame_motion = motion_q;
	assign results.alarm        = alarm_q;
	assign results.hit_count    = hits_q;

endmodule

/* rtl/core/mbmd_checker.sv */
// ----------------------------------------------------------------------------
// mbmd_checker
// Port-level checks of the motion detector: result timing, result
// consistency and reset behavior.
// ----------------------------------------------------------------------------
module mbmd_checker import mbmd_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             in_kind,
	input logic             in_fend,
	input logic             out_valid,
	input logic             out_ready,
	input logic             frame_motion,
	input logic             alarm,
	input logic [HIT_W-1:0] hit_count
);

	// A fresh result follows an accepted frame-end SAD transaction
	a_result_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready && (in_kind == KIND_SAD) && in_fend, 2))
		else $error("result without a frame-end transaction two cycles earlier");

	// Motion needs at least one hit
	a_motion_hits: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && frame_motion) |-> (hit_count != '0))
		else $error("frame motion with zero hits");

	// Alarm needs motion in this frame
	a_alarm_motion: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && alarm) |-> frame_motion)
		else $error("alarm without frame motion");

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=>
			(out_valid && $stable(frame_motion) && $stable(alarm) && $stable(hit_count)))
		else $error("stalled result changed");

	// Hold off items right after reset while the mask is cleared
	a_reset_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !in_ready)
		else $error("input ready during mask clear");

endmodule

bind masked_block_motion_detector mbmd_checker u_mbmd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (items.valid),
	.in_ready     (items.ready),
	.in_kind      (items.kind),
	.in_fend      (items.frame_end),
	.out_valid    (results.valid),
	.out_ready    (results.ready),
	.frame_motion (results.frame_motion),
	.alarm        (results.alarm),
	.hit_count    (results.hit_count)
);

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for masked_block_motion_detector. A walked table of
// directed steps (register writes, mask writes, SAD samples with hand-computed
// frame reports) is followed by random phases. Each phase programs new
// sensitivity and region count, primes a window of the mask and streams
// frames over it. An in-bench predictor of the mask, hit counter and motion
// history supplies the expected report of each frame-end SAD sample not in a
// typed table row. Both channel sides idle at random; one phase holds the
// result side off for a long stretch so the detector backs up into its input.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import mbmd_pkg::*;

	localparam int          SLOTS       = BLOCK_SLOTS_DEF;
	localparam int          HOT         = 24;
	localparam int          PHASES      = 8;
	localparam int          PHASE_ITEMS = 140;
	localparam int          SETTLE      = 8;
	localparam int          HOLD_CYCLES = 300;
	localparam int          IDLE_LIMIT  = 20000;
	localparam int          PLAN_LEN    = 24;

	typedef struct packed {
		logic             kind;
		logic [IDX_W-1:0] block_index;
		logic [SAD_W-1:0] sad_value;
		logic             region_bit;
		logic             frame_end;
	} item_t;

	typedef struct packed {
		logic             frame_motion;
		logic             alarm;
		logic [HIT_W-1:0] hit_count;
	} report_t;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_op_t;

	typedef struct {
		row_op_t              op;
		logic [CFG_IDX_W-1:0] addr;
		logic [CFG_DAT_W-1:0] data;
		logic                 kind;
		logic [IDX_W-1:0]     idx;
		logic [SAD_W-1:0]     sad;
		logic                 rbit;
		logic                 fend;
		int unsigned          reps;
		bit                   typed;
		logic                 want_motion;
		logic                 want_alarm;
		logic [HIT_W-1:0]     want_hits;
	} plan_row_t;

	// Directed steps; typed rows carry the report read straight off the rules
	plan_row_t plan [PLAN_LEN] = '{
		// op      addr        data  kind       idx   sad  bit end reps typ mot alm hits
		// mask is all clear after reset: nothing counts
		'{ROW_ITEM, CFG_SENS,   0,    KIND_SAD,  0,    255, 0,  1,  1,   1,  0,  0,  0},
		'{ROW_ITEM, CFG_SENS,   0,    KIND_MASK, 0,    0,   1,  0,  1,   0,  0,  0,  0},
		'{ROW_ITEM, CFG_SENS,   0,    KIND_MASK, 2047, 0,   1,  0,  1,   0,  0,  0,  0},
		'{ROW_ITEM, CFG_SENS,   0,    KIND_SAD,  0,    255, 0,  0,  1,   0,  0,  0,  0},
		// zero region count: any hit is motion
		'{ROW_ITEM, CFG_SENS,   0,    KIND_SAD,  2047, 255, 0,  1,  1,   1,  1,  0,  2},
		// second motion frame in a row raises the alarm
		'{ROW_ITEM, CFG_SENS,   0,    KIND_SAD,  2047, 255, 0,  1,  1,   1,  1,  1,  1},
		// SAD equal to the threshold does not count
		'{ROW_ITEM, CFG_SENS,   0,    KIND_SAD,  0,    25,  0,  1,  1,   1,  0,  0,  0},
		'{ROW_ITEM, CFG_SENS,   0,    KIND_SAD,  0,    26,  1,  1,  1,   1,  1,  0,  1},
		'{ROW_CFG,  CFG_SENS,   100,  KIND_SAD,  0,    0,   0,  0,  1,   0,  0,  0,  0},
		'{ROW_CFG,  CFG_RCOUNT, 2048, KIND_SAD,  0,    0,   0,  0,  1,   0,  0,  0,  0},
		'{ROW_ITEM, CFG_SENS,   0,    KIND_SAD,  0,    5,   0,  0,  1,   0,  0,  0,  0},
		'{ROW_ITEM, CFG_SENS,   0,    KIND_SAD,  0,    6,   0,  0,  1,   0,  0,  0,  0},
		'{ROW_ITEM, CFG_SENS,   0,    KIND_SAD,  2047, 255, 0,  0,  1,   0,  0,  0,  0},
		// unwatched block closes the frame; two hits are not above the floor of two
		'{ROW_ITEM, CFG_SENS,   0,    KIND_SAD,  1,    255, 0,  1,  1,   1,  0,  0,  2},
		// mask write ignores its SAD and frame end
		'{ROW_ITEM, CFG_SENS,   0,    KIND_MASK, 0,    255, 0,  1,  1,   0,  0,  0,  0},
		'{ROW_ITEM, CFG_SENS,   0,    KIND_SAD,  0,    255, 0,  1,  1,   1,  0,  0,  0},
		// upper data bits dropped; 127 acts as full sensitivity
		'{ROW_CFG,  CFG_SENS,   4095, KIND_SAD,  0,    0,   0,  0,  1,   0,  0,  0,  0},
		'{ROW_ITEM, CFG_SENS,   0,    KIND_MASK, 1365, 0,   1,  0,  1,   0,  0,  0,  0},
		// long frame over one watched block
		'{ROW_ITEM, CFG_SENS,   0,    KIND_SAD,  1365, 255, 0,  1,  20,  0,  0,  0,  0},
		'{ROW_CFG,  CFG_RCOUNT, 4095, KIND_SAD,  0,    0,   0,  0,  1,   0,  0,  0,  0},
		// small region: threshold capped to one
		'{ROW_CFG,  CFG_RCOUNT, 5,    KIND_SAD,  0,    0,   0,  0,  1,   0,  0,  0,  0},
		'{ROW_ITEM, CFG_SENS,   0,    KIND_SAD,  1365, 6,   0,  1,  2,   1,  1,  1,  2},
		// small region: threshold capped to zero
		'{ROW_CFG,  CFG_RCOUNT, 2,    KIND_SAD,  0,    0,   0,  0,  1,   0,  0,  0,  0},
		'{ROW_ITEM, CFG_SENS,   0,    KIND_SAD,  2047, 6,   0,  1,  1,   1,  1,  1,  1}
	};

	logic clk;
	logic arst_n;

	mbmd_item_if items_ch ();
	mbmd_res_if  results_ch ();
	mbmd_cfg_if  cfg_ch ();

	masked_block_motion_detector #(
		.BLOCK_SLOTS(SLOTS)
	) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.items  (items_ch),
		.results(results_ch),
		.cfg    (cfg_ch)
	);

	// Predictor state
	bit                mask_bits [SLOTS];
	logic [HIT_W-1:0]  hit_run;
	logic              last_motion;
	logic [SENS_W-1:0] sens_reg;
	logic [HIT_W-1:0]  rcount_reg;

	report_t frame_reports_q [$];

	int unsigned n_items;
	int unsigned n_writes;
	int unsigned n_reports;
	int unsigned n_motion;
	int unsigned n_alarms;
	int unsigned mismatches;
	int unsigned idle_cycles;
	bit          hold_req;
	int unsigned stall_left;
	int unsigned run_left;
	int unsigned gap;
	report_t     head;

	// Sensitivity with values above full scale acting as full scale
	function automatic int unsigned eff_sens();
		return (sens_reg > SENS_MAX) ? SENS_MAX : sens_reg;
	endfunction

	function automatic int unsigned sad_limit();
		return (100 - eff_sens()) / 5 + 5;
	endfunction

	// Advance the detector state by one transaction; returns 1 with a report
	// on a SAD frame end
	function automatic bit step_motion(input item_t it, output report_t rep);
		int unsigned lim;
		rep = '0;
		if (it.kind == KIND_MASK) begin
			if (int'(it.block_index) < SLOTS)
				mask_bits[it.block_index] = it.region_bit;
			return 1'b0;
		end
		if (int'(it.block_index) < SLOTS && mask_bits[it.block_index]
				&& it.sad_value > sad_limit() && hit_run != HIT_MAX)
			hit_run++;
		if (!it.frame_end)
			return 1'b0;
		lim = 30 * (100 - eff_sens()) / 100;
		if (lim < 2)
			lim = 2;
		if (lim >= rcount_reg / 3)
			lim = rcount_reg / 3;
		rep.frame_motion = hit_run > lim;
		rep.alarm        = rep.frame_motion & last_motion;
		rep.hit_count    = hit_run;
		last_motion      = rep.frame_motion;
		hit_run          = '0;
		return 1'b1;
	endfunction

	// Mostly short gaps, a few long ones, often none
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Offer one item, hold it until taken, then predict its report
	task automatic send_and_predict(input item_t it, input int unsigned idle,
			input bit typed, input report_t want);
		report_t rep;
		if (idle != 0) begin
			items_ch.valid <= 1'b0;
			repeat (idle) @(posedge clk);
		end
		items_ch.valid       <= 1'b1;
		items_ch.kind        <= it.kind;
		items_ch.block_index <= it.block_index;
		items_ch.sad_value   <= it.sad_value;
		items_ch.region_bit  <= it.region_bit;
		items_ch.frame_end   <= it.frame_end;
		do @(posedge clk); while (!items_ch.ready);
		n_items++;
		if (step_motion(it, rep))
			frame_reports_q.push_back(typed ? want : rep);
	endtask

	// Stop offering, wait for every pending report, then let the pipe settle
	task automatic drain_reports();
		items_ch.valid <= 1'b0;
		while (frame_reports_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] addr,
			input logic [CFG_DAT_W-1:0] data);
		drain_reports();
		cfg_ch.valid <= 1'b1;
		cfg_ch.addr  <= addr;
		cfg_ch.data  <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		case (addr)
			CFG_SENS: begin
				sens_reg = data[SENS_W-1:0];
			end
			CFG_RCOUNT: begin
				rcount_reg = data;
			end
			default: begin
			end
		endcase
		n_writes++;
	endtask

	// Clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Drive every input to a known value from time zero
	initial begin
		arst_n               <= 1'b0;
		items_ch.valid       <= 1'b0;
		items_ch.kind        <= KIND_MASK;
		items_ch.block_index <= '0;
		items_ch.sad_value   <= '0;
		items_ch.region_bit  <= 1'b0;
		items_ch.frame_end   <= 1'b0;
		cfg_ch.valid         <= 1'b0;
		cfg_ch.addr          <= CFG_SENS;
		cfg_ch.data          <= '0;
		results_ch.ready     <= 1'b0;
	end

	// Result side: random ready, long runs now and then, one long hold on request
	initial begin
		stall_left = 0;
		run_left   = 0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req   = 1'b0;
				stall_left = HOLD_CYCLES;
			end
			if (stall_left != 0) begin
				results_ch.ready <= 1'b0;
				stall_left--;
			end else if (run_left != 0) begin
				results_ch.ready <= 1'b1;
				run_left--;
			end else begin
				gap      = pick_gap();
				run_left = ($urandom_range(0, 19) == 0) ? 200 : $urandom_range(1, 24);
				if (gap != 0) begin
					results_ch.ready <= 1'b0;
					stall_left = gap - 1;
				end else begin
					results_ch.ready <= 1'b1;
				end
			end
			@(posedge clk);
		end
	end

	// Check each frame report against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && results_ch.valid && results_ch.ready) begin
			if (frame_reports_q.size() == 0) begin
				$error("frame report with no frame end pending: motion %0d alarm %0d hits %0d",
					results_ch.frame_motion, results_ch.alarm, results_ch.hit_count);
				mismatches++;
			end else begin
				head = frame_reports_q.pop_front();
				n_reports++;
				if (head.frame_motion)
					n_motion++;
				if (head.alarm)
					n_alarms++;
				if (results_ch.frame_motion !== head.frame_motion) begin
					$error("frame_motion: expected %0d, got %0d",
						head.frame_motion, results_ch.frame_motion);
					mismatches++;
				end
				if (results_ch.alarm !== head.alarm) begin
					$error("alarm: expected %0d, got %0d", head.alarm, results_ch.alarm);
					mismatches++;
				end
				if (results_ch.hit_count !== head.hit_count) begin
					$error("hit_count: expected %0d, got %0d",
						head.hit_count, results_ch.hit_count);
					mismatches++;
				end
			end
		end
	end

	// Watchdog: end the run when no transaction moves for too long
	always @(posedge clk) begin
		if ((items_ch.valid && items_ch.ready) || (results_ch.valid && results_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == IDLE_LIMIT) begin
			$display("Watchdog: no transaction for %0d cycles, %0d reports pending",
				IDLE_LIMIT, frame_reports_q.size());
			$display("Some tests failed");
			$finish;
		end
	end

	// Stimulus
	item_t       it;
	report_t     want;
	int unsigned k;
	int unsigned ph;
	int unsigned r;
	int unsigned hot_base;
	int unsigned end_odds;
	int unsigned lim;
	bit          calm;

	initial begin
		hit_run     = '0;
		last_motion = 1'b0;
		sens_reg    = '0;
		rcount_reg  = '0;
		hold_req    = 1'b0;
		idle_cycles = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Walk the directed table
		foreach (plan[i]) begin
			if (plan[i].op == ROW_CFG) begin
				write_reg(plan[i].addr, plan[i].data);
			end else begin
				want.frame_motion = plan[i].want_motion;
				want.alarm        = plan[i].want_alarm;
				want.hit_count    = plan[i].want_hits;
				for (k = 0; k < plan[i].reps; k++) begin
					it.kind        = plan[i].kind;
					it.block_index = plan[i].idx;
					it.sad_value   = plan[i].sad;
					it.region_bit  = plan[i].rbit;
					it.frame_end   = (k == plan[i].reps - 1) ? plan[i].fend : 1'b0;
					send_and_predict(it, pick_gap(), plan[i].typed, want);
				end
			end
		end

		// Random phases, each with its own register setting and mask window
		for (ph = 0; ph < PHASES; ph++) begin
			r = $urandom_range(0, 5);
			case (r)
				0: write_reg(CFG_SENS, '0);
				1: write_reg(CFG_SENS, CFG_DAT_W'(SENS_MAX));
				2: write_reg(CFG_SENS, CFG_DAT_W'($urandom_range(101, 4095)));
				default: write_reg(CFG_SENS, CFG_DAT_W'($urandom_range(0, 100)));
			endcase
			r = $urandom_range(0, 5);
			case (r)
				0: write_reg(CFG_RCOUNT, '0);
				1: write_reg(CFG_RCOUNT, CFG_DAT_W'(SLOTS));
				2: write_reg(CFG_RCOUNT, '1);
				3: write_reg(CFG_RCOUNT, CFG_DAT_W'($urandom_range(0, 8)));
				4: write_reg(CFG_RCOUNT, CFG_DAT_W'($urandom_range(0, 120)));
				default: write_reg(CFG_RCOUNT, CFG_DAT_W'($urandom_range(0, 4095)));
			endcase

			hot_base = $urandom_range(0, SLOTS - HOT);
			calm     = (ph % 4 == 3) || (ph == 1);
			end_odds = (ph == 1) ? 2 : $urandom_range(4, 40);
			lim      = sad_limit();

			// Back up the result side while short frames keep coming
			if (ph == 1)
				hold_req = 1'b1;

			// Prime the window: mostly watched blocks
			for (k = 0; k < HOT; k++) begin
				it.kind        = KIND_MASK;
				it.block_index = IDX_W'(hot_base + k);
				it.sad_value   = SAD_W'($urandom);
				it.region_bit  = ($urandom_range(0, 3) != 0);
				it.frame_end   = 1'($urandom_range(0, 1));
				send_and_predict(it, calm ? 0 : pick_gap(), 1'b0, want);
			end

			// Frames over the window, with stray mask writes and far blocks
			for (k = 0; k < PHASE_ITEMS; k++) begin
				it.region_bit = 1'($urandom_range(0, 1));
				if ($urandom_range(0, 99) < 15) begin
					it.kind        = KIND_MASK;
					it.block_index = $urandom_range(0, 1) ? IDX_W'(hot_base + $urandom_range(0, HOT - 1))
						: IDX_W'($urandom);
					it.sad_value   = SAD_W'($urandom);
					it.frame_end   = 1'($urandom_range(0, 1));
				end else begin
					it.kind        = KIND_SAD;
					it.block_index = ($urandom_range(0, 4) != 0)
						? IDX_W'(hot_base + $urandom_range(0, HOT - 1)) : IDX_W'($urandom);
					r = $urandom_range(0, 99);
					if (r < 45)
						it.sad_value = SAD_W'($urandom);
					else if (r < 80)
						it.sad_value = SAD_W'(lim - 1 + $urandom_range(0, 2));
					else
						it.sad_value = $urandom_range(0, 1) ? '1 : '0;
					it.frame_end   = ($urandom_range(1, end_odds) == 1);
				end
				send_and_predict(it, calm ? 0 : pick_gap(), 1'b0, want);
			end
		end

		drain_reports();
		$display("Coverage: %0d items, %0d register writes over %0d random phases",
			n_items, n_writes, PHASES);
		$display("Coverage: %0d frame reports, %0d with motion, %0d alarms",
			n_reports, n_motion, n_alarms);
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
